@@ rtl/avt_pkg.sv @@
package avt_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned RegW   = 64;
  localparam int unsigned ProdW  = CoordW + CoefW;      // one product
  localparam int unsigned PairW  = ProdW + 1;           // sum of two terms
  localparam int unsigned TotalW = ProdW + 2;           // sum of four terms
  localparam int unsigned FracDrop = 24;                // Q24.40 -> Q16.16
  localparam int unsigned TransShift = 16;              // Q8.24 -> Q.40
  localparam int unsigned QuotW = TotalW - FracDrop;

  localparam logic [RegW-1:0] Row0XyReset = 64'h0000_0000_0100_0000;
  localparam logic [RegW-1:0] Row0ZwReset = 64'h0;
  localparam logic [RegW-1:0] Row1XyReset = 64'h0100_0000_0000_0000;
  localparam logic [RegW-1:0] Row1ZwReset = 64'h0;
  localparam logic [RegW-1:0] Row2XyReset = 64'h0;
  localparam logic [RegW-1:0] Row2ZwReset = 64'h0000_0000_0100_0000;

  localparam logic signed [CoordW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_ROW0_XY = 3'd0,
    REG_ROW0_ZW = 3'd1,
    REG_ROW1_XY = 3'd2,
    REG_ROW1_ZW = 3'd3,
    REG_ROW2_XY = 3'd4,
    REG_ROW2_ZW = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_in;
    logic signed [CoordW-1:0] y_in;
    logic signed [CoordW-1:0] z_in;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_out;
    logic signed [CoordW-1:0] y_out;
    logic signed [CoordW-1:0] z_out;
    logic                     last_out;
  } out_item_t;

  // one row of the matrix as used by the datapath
  typedef struct packed {
    logic signed [CoefW-1:0] cx;
    logic signed [CoefW-1:0] cy;
    logic signed [CoefW-1:0] cz;
    logic signed [CoefW-1:0] t;
  } row_coef_t;

  // per-stage data load strobes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ld_t;

endpackage

@@ rtl/avt_pipe_ctrl.sv @@
module avt_pipe_ctrl
  import avt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_ld_t ld
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // a stage takes new data when empty or when its content moves on
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ready  = rdy1;
  assign out_valid = v3_r;

  assign ld.ld1 = in_valid && rdy1;
  assign ld.ld2 = v1_r && rdy2;
  assign ld.ld3 = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r))
    else $error("pipeline not empty after reset");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("stage 2 item lost under stall");

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without a stage 2 item");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && !out_ready))
    else $error("input blocked while pipeline has room");

endmodule

@@ rtl/avt_row.sv @@
module avt_row
  import avt_pkg::*;
(
  input  logic                     clk,
  input  row_coef_t                coef,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  stage_ld_t                ld,
  output logic signed [CoordW-1:0] res
);

  logic signed [ProdW-1:0]  px_r, py_r, pz_r;
  logic signed [ProdW-1:0]  px_nxt, py_nxt, pz_nxt;
  logic signed [PairW-1:0]  sa_r, sb_r, sa_nxt, sb_nxt;
  logic signed [TotalW-1:0] total;
  logic signed [QuotW-1:0]  quot;
  logic signed [CoordW-1:0] res_r, res_nxt;

  // stage 1: three products, Q24.40
  always_comb begin
    px_nxt = x * coef.cx;
    py_nxt = y * coef.cy;
    pz_nxt = z * coef.cz;
  end

  // stage 2: pairwise sums; translation aligned to Q.40
  always_comb begin
    sa_nxt = {px_r[ProdW-1], px_r} + {py_r[ProdW-1], py_r};
    sb_nxt = {pz_r[ProdW-1], pz_r}
           + {{(PairW-CoefW-TransShift){coef.t[CoefW-1]}}, coef.t, {TransShift{1'b0}}};
  end

  // stage 3: final add, floor to Q16.16, saturate
  always_comb begin
    total = {sa_r[PairW-1], sa_r} + {sb_r[PairW-1], sb_r};
    quot  = total[TotalW-1:FracDrop];
    if (quot[QuotW-1:CoordW-1] != {(QuotW-CoordW+1){quot[QuotW-1]}}) begin
      res_nxt = quot[QuotW-1] ? SatMin : SatMax;
    end else begin
      res_nxt = quot[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
    if (ld.ld2) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
    if (ld.ld3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/affine_vertex_transform_unit.sv @@
// Affine vertex transform: each vertex (x, y, z, Q16.16) is multiplied by
// the upper three rows of a column-major 4x4 matrix with w = 1, and each
// result is floored to Q16.16 and saturated to 32 bits; last passes along.
// Throughput is one vertex per clock while the output is not stalled. Three
// register stages (products, pairwise sums, final sum and saturate) lie
// between the input transfer and out_valid. A stalled output still lets the
// input side fill the empty stages.
// Coefficients are signed Q8.24, two per 64-bit register (x/y and z/trans
// per row); they reset to the identity and may only be written while no
// vertex is in flight.
module affine_vertex_transform_unit
  import avt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_idx,
  input  logic [RegW-1:0] cfg_wdata
);

  logic [RegW-1:0] row0_xy_r, row0_zw_r, row1_xy_r, row1_zw_r, row2_xy_r, row2_zw_r;
  logic            last1_r, last2_r, last3_r;
  stage_ld_t       ld;
  row_coef_t       coef0, coef1, coef2;
  logic signed [CoordW-1:0] res0, res1, res2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_xy_r <= Row0XyReset;
      row0_zw_r <= Row0ZwReset;
      row1_xy_r <= Row1XyReset;
      row1_zw_r <= Row1ZwReset;
      row2_xy_r <= Row2XyReset;
      row2_zw_r <= Row2ZwReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW0_XY: row0_xy_r <= cfg_wdata;
        REG_ROW0_ZW: row0_zw_r <= cfg_wdata;
        REG_ROW1_XY: row1_xy_r <= cfg_wdata;
        REG_ROW1_ZW: row1_zw_r <= cfg_wdata;
        REG_ROW2_XY: row2_xy_r <= cfg_wdata;
        REG_ROW2_ZW: row2_zw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign coef0 = '{cx: row0_xy_r[CoefW-1:0], cy: row0_xy_r[RegW-1:CoefW],
                   cz: row0_zw_r[CoefW-1:0], t: row0_zw_r[RegW-1:CoefW]};
  assign coef1 = '{cx: row1_xy_r[CoefW-1:0], cy: row1_xy_r[RegW-1:CoefW],
                   cz: row1_zw_r[CoefW-1:0], t: row1_zw_r[RegW-1:CoefW]};
  assign coef2 = '{cx: row2_xy_r[CoefW-1:0], cy: row2_xy_r[RegW-1:CoefW],
                   cz: row2_zw_r[CoefW-1:0], t: row2_zw_r[RegW-1:CoefW]};

  avt_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  avt_row u_row0 (
    .clk (clk), .coef (coef0),
    .x (in_data.x_in), .y (in_data.y_in), .z (in_data.z_in),
    .ld (ld), .res (res0)
  );

  avt_row u_row1 (
    .clk (clk), .coef (coef1),
    .x (in_data.x_in), .y (in_data.y_in), .z (in_data.z_in),
    .ld (ld), .res (res1)
  );

  avt_row u_row2 (
    .clk (clk), .coef (coef2),
    .x (in_data.x_in), .y (in_data.y_in), .z (in_data.z_in),
    .ld (ld), .res (res2)
  );

  // last flag rides alongside the datapath stages
  always_ff @(posedge clk) begin
    if (ld.ld1) last1_r <= in_data.last_in;
    if (ld.ld2) last2_r <= last1_r;
    if (ld.ld3) last3_r <= last2_r;
  end

  assign out_data = '{x_out: res0, y_out: res1, z_out: res2, last_out: last3_r};

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import avt_pkg::*;

  localparam int PipeLatency   = 3;
  localparam int DrainSlack    = 2 * PipeLatency + 4;
  localparam int HoldOffCycles = 120;
  localparam int WatchdogLimit = 2000;
  localparam int RandomSets    = 9;

  localparam logic [2:0] IdxSpare6 = 3'd6;
  localparam logic [2:0] IdxSpare7 = 3'd7;

  localparam logic [CoefW-1:0] CoefOne       = 32'h0100_0000;
  localparam logic [CoefW-1:0] CoefMinusOne  = 32'hFF00_0000;
  localparam logic [CoefW-1:0] CoefHalf      = 32'h0080_0000;
  localparam logic [CoefW-1:0] CoefMinusHalf = 32'hFF80_0000;
  localparam logic [CoefW-1:0] CoefTop       = 32'h7FFF_FFFF;
  localparam logic [CoefW-1:0] CoefBottom    = 32'h8000_0000;
  localparam int unsigned CoefSpan  = 32'h0200_0000;  // +-2.0 in Q8.24
  localparam int unsigned CoordSpan = 32'h0010_0000;  // +-16.0 in Q16.16

  typedef enum logic {STEP_WRITE, STEP_VERTEX} step_kind_t;
  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct {
    step_kind_t      kind;
    logic [2:0]      idx;
    logic [RegW-1:0] wdata;
    in_item_t        vtx;
    bit              typed;
    out_item_t       vexp;
  } dir_step_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_we    = 1'b0;
  logic [2:0]      cfg_idx   = '0;
  logic [RegW-1:0] cfg_wdata = '0;

  logic [RegW-1:0] coef_regs [6];
  out_item_t       expected_vertices [$];
  dir_step_t       steps [$];

  int       errors;
  int       vertices_sent;
  int       directed_vertices;
  int       reg_writes;
  int       coef_sets;
  int       burst_left;
  int       hold_left;
  int       mode_left;
  int       rx_cycle;
  int       quiet_cycles;
  bit       hold_off_pending;
  rx_mode_t rx_mode;

  affine_vertex_transform_unit i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_we,
    .cfg_idx,
    .cfg_wdata
  );

  always #1 clk = ~clk;

  // Exact sum in Q.40 units, floored to Q16.16 by an arithmetic shift, then clamped.
  function automatic logic signed [CoordW-1:0] transformed_coord(
      logic [RegW-1:0] xy, logic [RegW-1:0] zw, in_item_t v);
    logic signed [71:0] cx, cy, cz, t, vx, vy, vz, acc;
    cx  = signed'(xy[CoefW-1:0]);
    cy  = signed'(xy[RegW-1:CoefW]);
    cz  = signed'(zw[CoefW-1:0]);
    t   = signed'(zw[RegW-1:CoefW]);
    vx  = v.x_in;
    vy  = v.y_in;
    vz  = v.z_in;
    acc = cx * vx + cy * vy + cz * vz + (t <<< TransShift);
    acc = acc >>> FracDrop;
    if (acc > SatMax) return SatMax;
    if (acc < SatMin) return SatMin;
    return acc[CoordW-1:0];
  endfunction

  function automatic out_item_t transform_vertex(in_item_t v);
    out_item_t r;
    r.x_out    = transformed_coord(coef_regs[REG_ROW0_XY], coef_regs[REG_ROW0_ZW], v);
    r.y_out    = transformed_coord(coef_regs[REG_ROW1_XY], coef_regs[REG_ROW1_ZW], v);
    r.z_out    = transformed_coord(coef_regs[REG_ROW2_XY], coef_regs[REG_ROW2_ZW], v);
    r.last_out = v.last_in;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [CoordW-1:0] want,
                                  logic [CoordW-1:0] got);
    if (got === want) return 1'b1;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return CoefOne;
      2:       return CoefMinusOne;
      3:       return '0;
      default: return $urandom_range(0, 2 * CoefSpan) - CoefSpan;
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0:       return SatMax;
          1:       return SatMin;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 2 * CoordSpan) - CoordSpan;
    endcase
  endfunction

  function automatic in_item_t random_vertex();
    in_item_t v;
    v.x_in    = rand_coord();
    v.y_in    = rand_coord();
    v.z_in    = rand_coord();
    v.last_in = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  function automatic void add_write(logic [2:0] idx, logic [RegW-1:0] data);
    dir_step_t s;
    s.kind  = STEP_WRITE;
    s.idx   = idx;
    s.wdata = data;
    s.vtx   = '0;
    s.typed = 1'b0;
    s.vexp  = '0;
    steps.push_back(s);
  endfunction

  function automatic void add_vertex(logic signed [CoordW-1:0] x, y, z, logic last,
                                     bit typed, logic signed [CoordW-1:0] ex, ey, ez);
    dir_step_t s;
    s.kind  = STEP_VERTEX;
    s.idx   = '0;
    s.wdata = '0;
    s.vtx   = '{x_in: x, y_in: y, z_in: z, last_in: last};
    s.typed = typed;
    s.vexp  = '{x_out: ex, y_out: ey, z_out: ez, last_out: last};
    steps.push_back(s);
  endfunction

  // Drop valid, let every vertex in flight come out, then a little slack.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [2:0] idx, logic [RegW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx <= REG_ROW2_ZW) coef_regs[idx] = data;
    reg_writes++;
  endtask

  task automatic send_vertex(in_item_t v, bit typed, out_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_vertices.push_back(typed ? want : transform_vertex(v));
    burst_left--;
    vertices_sent++;
  endtask

  // Result side: check each transfer, then pick next cycle's ready.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want = expected_vertices.pop_front();
        if (!(field_ok("x_out", want.x_out, out_data.x_out) &
              field_ok("y_out", want.y_out, out_data.y_out) &
              field_ok("z_out", want.z_out, out_data.z_out) &
              field_ok("last_out", 32'(want.last_out), 32'(out_data.last_out))))
          errors++;
      end
    end

    if (hold_off_pending) begin
      hold_off_pending = 1'b0;
      hold_left = HoldOffCycles;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_STREAM:   out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ready <= (rx_cycle % 4) != 0;
        default:     out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [RegW-1:0] word;
    bit              writing;

    coef_regs[REG_ROW0_XY] = Row0XyReset;
    coef_regs[REG_ROW0_ZW] = Row0ZwReset;
    coef_regs[REG_ROW1_XY] = Row1XyReset;
    coef_regs[REG_ROW1_ZW] = Row1ZwReset;
    coef_regs[REG_ROW2_XY] = Row2XyReset;
    coef_regs[REG_ROW2_ZW] = Row2ZwReset;
    coef_sets = 1;
    writing   = 1'b0;

    // reset matrix is the identity, so vertices come back unchanged
    add_vertex(0, 0, 0, 1'b0, 1'b1, 0, 0, 0);
    add_vertex(SatMax, SatMax, SatMax, 1'b1, 1'b1, SatMax, SatMax, SatMax);
    add_vertex(SatMin, SatMin, SatMin, 1'b0, 1'b1, SatMin, SatMin, SatMin);
    add_vertex(SatMax, SatMin, -1, 1'b1, 1'b1, SatMax, SatMin, -1);
    add_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000, 1'b0, 1'b1,
               32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000);
    add_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_0000, 1'b1, 1'b1,
               32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_0000);

    // extreme coefficients: sums far past both ends of the range
    add_write(REG_ROW0_XY, {CoefTop, CoefTop});
    add_write(REG_ROW0_ZW, {CoefTop, CoefTop});
    add_write(REG_ROW1_XY, {CoefBottom, CoefBottom});
    add_write(REG_ROW1_ZW, {CoefBottom, CoefBottom});
    add_write(REG_ROW2_XY, {CoefHalf, CoefHalf});
    add_write(REG_ROW2_ZW, {32'hFFFF_FFFF, CoefHalf});
    add_write(IdxSpare6, '1);  // out-of-range indexes must not land anywhere
    add_write(IdxSpare7, {2{32'h5555_5555}});
    add_vertex(SatMax, SatMax, SatMax, 1'b1, 1'b1, SatMax, SatMin, SatMax);
    add_vertex(SatMin, SatMin, SatMin, 1'b0, 1'b1, SatMin, SatMax, SatMin);
    add_vertex(-1, 0, 0, 1'b0, 1'b0, 0, 0, 0);
    add_vertex(1, -1, 0, 1'b1, 1'b0, 0, 0, 0);
    add_vertex(0, 0, -3, 1'b0, 1'b0, 0, 0, 0);
    add_vertex(32'sh00FF_FFFF, 1, -256, 1'b1, 1'b0, 0, 0, 0);

    // halves on odd inputs: results floor toward minus infinity
    add_write(REG_ROW0_XY, {32'h0, CoefHalf});
    add_write(REG_ROW0_ZW, '0);
    add_write(REG_ROW1_XY, {CoefHalf, 32'h0});
    add_write(REG_ROW1_ZW, '0);
    add_write(REG_ROW2_XY, '0);
    add_write(REG_ROW2_ZW, {32'h0, CoefMinusHalf});
    add_vertex(-1, -1, 1, 1'b1, 1'b1, -1, -1, -1);
    add_vertex(1, 1, -1, 1'b0, 1'b1, 0, 0, 0);
    add_vertex(3, -3, 3, 1'b1, 1'b1, 1, -2, -2);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[k]) begin
      if (steps[k].kind == STEP_WRITE) begin
        if (!writing) begin
          wait_idle();
          writing = 1'b1;
          coef_sets++;
        end
        write_reg(steps[k].idx, steps[k].wdata);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_vertex(steps[k].vtx, steps[k].typed, steps[k].vexp);
        directed_vertices++;
      end
    end

    // first four sets are the register extremes, the rest random matrices
    for (int s = 0; s < RandomSets; s++) begin
      wait_idle();
      coef_sets++;
      for (int r = REG_ROW0_XY; r <= REG_ROW2_ZW; r++) begin
        case (s)
          0:       word = {CoefTop, CoefTop};
          1:       word = {CoefBottom, CoefBottom};
          2:       word = '1;
          3:       word = '0;
          default: word = {rand_coef(), rand_coef()};
        endcase
        write_reg(3'(r), word);
      end
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? IdxSpare6 : IdxSpare7, {$urandom(), $urandom()});
      cfg_we <= 1'b0;
      for (int i = 0; i < ((s < 4) ? 40 : 210); i++) begin
        // long output stall while vertices keep coming: pipeline fills, input stalls
        if (s == 5 && i == 40) hold_off_pending = 1'b1;
        send_vertex(random_vertex(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Run covered %0d vertices (%0d directed) over %0d coefficient sets,",
             vertices_sent, directed_vertices, coef_sets);
    $display("%0d register writes incl. out-of-range indexes, a %0d-cycle output hold-off.",
             reg_writes, HoldOffCycles);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ affine_vertex_transform_unit.f @@
rtl/avt_pkg.sv
rtl/avt_pipe_ctrl.sv
rtl/avt_row.sv
rtl/affine_vertex_transform_unit.sv
tb/sv/testbench.sv
